/* design/vgcd_pkg.sv */
// Shared constants and types for the voxel grid centroid downsampler.
package vgcd_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349663;
    localparam logic [31:0] PRIME_Z = 32'd83492791;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_SKIPPED  = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_CENTROID = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic REG_INVERSE_LEAF = 1'b0;
    localparam logic REG_KEEP_ALL     = 1'b1;

    // one table entry: keys, sums, count
    localparam int ENTRY_W = 3 * 32 + 3 * 64 + 32;

    typedef struct packed {
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] sz;
        logic [31:0] cnt;
    } t_entry;

    // request to the shared divider and its answer
    typedef struct packed {
        logic        start;
        logic [63:0] mag;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

/* design/vgcd_ram.sv */
// Generic single-port RAM with registered read.
module vgcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* design/vgcd_div.sv */
// Restoring divider, one quotient bit a cycle, 64-bit dividend by 32-bit divisor.
module vgcd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vgcd_pkg::t_div_req i_req,
    output vgcd_pkg::t_div_rsp o_rsp
);
    logic        r_busy;
    logic [6:0]  r_left;
    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [32:0] w_shift;
    logic [32:0] w_sub;
    logic        r_done;

    always_comb begin
        w_shift = {r_rem[31:0], r_quo[63]};
        w_sub   = w_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_left <= 7'd64;
            end else if (r_busy) begin
                r_left <= r_left - 7'd1;
                if (r_left == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.mag;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            if (!w_sub[32]) begin
                r_rem <= w_sub;
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

/* design/voxel_grid_centroid_downsampler_core.sv */
// Top level: sequencer, key/hash unit, table and centroid drain.
//
//  channel | dir | handshake        | payload
//  s_axis  | in  | tvalid/tready    | tdata x,y,z,finite; tuser req_type
//  m_axis  | out | tvalid/tready    | tdata status,cx,cy,cz,entries; tlast
//  cfg     | in  | i_cfg_we         | index, 32-bit data
//
// An add's result word follows three key multiplies, three hash multiplies and one read and
// check per probe (up to 64); a non-finite point skips the hash, and passthrough scans from
// slot 0 for a free slot. Keys and hash share one 33x33 signed multiplier; the RAM reads late.
// A take scans 64 slots, each with a read and a check; a used slot adds three runs of the shared
// 64-step divider (three means). Reset clears the valid bits at once.
// A stalled result holds the block; the next word is taken only after the result is gone.
module voxel_grid_centroid_downsampler_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // x[31:0], y, z, finite, zero pad
    input  logic         s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // status, cx, cy, cz, entries_held, pad
    output logic         m_axis_tlast,  // last_of_run
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    localparam int IW = vgcd_pkg::IDX_W;
    localparam int CW = vgcd_pkg::CNT_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MULX  = 5'd1;
    localparam logic [4:0] S_MULY  = 5'd2;
    localparam logic [4:0] S_MULZ  = 5'd3;
    localparam logic [4:0] S_HX    = 5'd4;
    localparam logic [4:0] S_HY    = 5'd5;
    localparam logic [4:0] S_HZ    = 5'd6;
    localparam logic [4:0] S_PRD   = 5'd7;
    localparam logic [4:0] S_PCHK  = 5'd8;
    localparam logic [4:0] S_OUT   = 5'd9;
    localparam logic [4:0] S_TRD   = 5'd10;
    localparam logic [4:0] S_TCHK  = 5'd11;
    localparam logic [4:0] S_DIV   = 5'd12;
    localparam logic [4:0] S_DWAIT = 5'd13;
    localparam logic [4:0] S_TOUT  = 5'd14;
    localparam logic [4:0] S_PSCAN = 5'd15;

    logic [4:0]  r_state;
    logic [31:0] r_inv;
    logic        r_keep;

    logic [31:0] r_px, r_py, r_pz;
    logic        r_fin;
    logic [31:0] r_kx, r_ky, r_kz;
    logic [31:0] r_hash;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_probes;
    logic [CW-1:0] r_held;
    logic [vgcd_pkg::TABLE_DEPTH-1:0] r_used;
    logic [1:0]  r_axis;
    logic [31:0] r_cx, r_cy, r_cz;
    logic        r_any;

    logic [2:0]  r_ostat;
    logic        r_olast;
    logic        r_ovalid;

    // shared multiplier: signed 33x33 -> 66 (only the low 64 bits used)
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;

    vgcd_pkg::t_entry w_rd, w_wr;
    logic [vgcd_pkg::ENTRY_W-1:0] w_rd_bits;
    logic w_we;

    vgcd_pkg::t_div_req w_dreq;
    vgcd_pkg::t_div_rsp w_drsp;

    logic [63:0] w_dsum;
    logic        w_dneg;
    logic [63:0] w_dq;
    logic [31:0] w_den;
    logic        w_match;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_MULX: begin
                w_ma = $signed({r_px[31], r_px});
                w_mb = $signed({1'b0, r_inv});
            end
            S_MULY: begin
                w_ma = $signed({r_py[31], r_py});
                w_mb = $signed({1'b0, r_inv});
            end
            S_MULZ: begin
                w_ma = $signed({r_pz[31], r_pz});
                w_mb = $signed({1'b0, r_inv});
            end
            S_HX: begin
                w_ma = $signed({1'b0, r_kx});
                w_mb = $signed({1'b0, vgcd_pkg::PRIME_X});
            end
            S_HY: begin
                w_ma = $signed({1'b0, r_ky});
                w_mb = $signed({1'b0, vgcd_pkg::PRIME_Y});
            end
            S_HZ: begin
                w_ma = $signed({1'b0, r_kz});
                w_mb = $signed({1'b0, vgcd_pkg::PRIME_Z});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_mp = w_ma * w_mb;
    end

    assign w_rd = vgcd_pkg::t_entry'(w_rd_bits);

    vgcd_ram #(.WIDTH(vgcd_pkg::ENTRY_W), .DEPTH(vgcd_pkg::TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (r_idx),
        .i_wdata (w_wr),
        .o_rdata (w_rd_bits)
    );

    vgcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    assign w_match = (w_rd.kx == r_kx) && (w_rd.ky == r_ky) && (w_rd.kz == r_kz);

    // table write: claim or accumulate
    always_comb begin
        w_we = 1'b0;
        w_wr = w_rd;
        if (r_state == S_PSCAN && !r_used[r_idx]) begin
            w_we = 1'b1;
        end
        if (r_state == S_PCHK && !r_used[r_idx]) begin
            w_we = 1'b1;
        end
        if (w_we) begin
            w_wr.kx  = r_kx;
            w_wr.ky  = r_ky;
            w_wr.kz  = r_kz;
            w_wr.sx  = {{32{r_px[31]}}, r_px};
            w_wr.sy  = {{32{r_py[31]}}, r_py};
            w_wr.sz  = {{32{r_pz[31]}}, r_pz};
            w_wr.cnt = 32'd1;
        end else if (r_state == S_PCHK && w_match && w_rd.cnt != 32'hFFFF_FFFF) begin
            w_we     = 1'b1;
            w_wr.sx  = w_rd.sx + {{32{r_px[31]}}, r_px};
            w_wr.sy  = w_rd.sy + {{32{r_py[31]}}, r_py};
            w_wr.sz  = w_rd.sz + {{32{r_pz[31]}}, r_pz};
            w_wr.cnt = w_rd.cnt + 32'd1;
        end
    end

    // divider operands for the current axis
    always_comb begin
        unique case (r_axis)
            2'd0:    w_dsum = w_rd.sx;
            2'd1:    w_dsum = w_rd.sy;
            default: w_dsum = w_rd.sz;
        endcase
        w_den  = (w_rd.cnt == 32'd0) ? 32'd1 : w_rd.cnt;
        w_dneg = w_dsum[63];
        w_dreq.start = (r_state == S_DIV);
        w_dreq.mag   = (w_dneg ? (64'd0 - w_dsum) : w_dsum) + {33'd0, w_den[31:1]};
        w_dreq.den   = w_den;
        w_dq = w_dneg ? (64'd0 - w_drsp.quo) : w_drsp.quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= 32'd65536;
            r_keep <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vgcd_pkg::REG_INVERSE_LEAF: r_inv <= i_cfg_data;
                vgcd_pkg::REG_KEEP_ALL:     r_keep <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_held   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_px  <= s_axis_tdata[31:0];
                    r_py  <= s_axis_tdata[63:32];
                    r_pz  <= s_axis_tdata[95:64];
                    r_fin <= s_axis_tdata[96];
                    r_idx <= '0;
                    r_any <= 1'b0;
                    r_state <= s_axis_tuser ? S_TRD : S_MULX;
                end
                S_MULX: begin r_kx <= w_mp[63:32]; r_state <= S_MULY; end
                S_MULY: begin r_ky <= w_mp[63:32]; r_state <= S_MULZ; end
                S_MULZ: begin
                    r_kz <= w_mp[63:32];
                    if (r_keep) begin
                        r_idx <= '0;
                        r_probes <= '0;
                        r_state <= S_PSCAN;
                    end else if (!r_fin) begin
                        r_ostat <= vgcd_pkg::ST_SKIPPED;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_HX;
                    end
                end
                S_HX: begin r_hash <= w_mp[31:0]; r_state <= S_HY; end
                S_HY: begin r_hash <= r_hash ^ w_mp[31:0]; r_state <= S_HZ; end
                S_HZ: begin
                    r_idx <= IW'((r_hash ^ w_mp[31:0]) & 32'(vgcd_pkg::TABLE_DEPTH - 1));
                    r_probes <= '0;
                    r_state <= S_PRD;
                end
                S_PSCAN: begin
                    if (!r_used[r_idx]) begin
                        r_used[r_idx] <= 1'b1;
                        r_held  <= r_held + CW'(1);
                        r_ostat <= vgcd_pkg::ST_ACCEPTED;
                        r_state <= S_OUT;
                    end else if (r_probes == CW'(vgcd_pkg::TABLE_DEPTH - 1)) begin
                        r_ostat <= vgcd_pkg::ST_DROPPED;
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                        r_probes <= r_probes + CW'(1);
                    end
                end
                S_PRD: r_state <= S_PCHK;
                S_PCHK: begin
                    if (!r_used[r_idx]) begin
                        r_used[r_idx] <= 1'b1;
                        r_held  <= r_held + CW'(1);
                        r_ostat <= vgcd_pkg::ST_ACCEPTED;
                        r_state <= S_OUT;
                    end else if (w_match) begin
                        r_ostat <= (w_rd.cnt == 32'hFFFF_FFFF) ?
                                   vgcd_pkg::ST_DROPPED : vgcd_pkg::ST_ACCEPTED;
                        r_state <= S_OUT;
                    end else if (r_probes == CW'(vgcd_pkg::TABLE_DEPTH - 1)) begin
                        r_ostat <= vgcd_pkg::ST_DROPPED;
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                        r_probes <= r_probes + CW'(1);
                        r_state <= S_PRD;
                    end
                end
                S_OUT: begin
                    r_cx <= '0; r_cy <= '0; r_cz <= '0;
                    r_olast  <= 1'b1;
                    r_ovalid <= 1'b1;
                    r_state  <= S_TOUT;
                end
                S_TRD: r_state <= S_TCHK;
                S_TCHK: begin
                    if (r_used[r_idx]) begin
                        r_axis  <= 2'd0;
                        r_state <= S_DIV;
                    end else if (r_idx == IW'(vgcd_pkg::TABLE_DEPTH - 1)) begin
                        r_held <= '0;
                        if (!r_any) begin
                            r_ostat  <= vgcd_pkg::ST_EMPTY;
                            r_cx <= '0; r_cy <= '0; r_cz <= '0;
                            r_olast  <= 1'b1;
                            r_ovalid <= 1'b1;
                            r_state  <= S_TOUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx <= r_idx + IW'(1);
                        r_state <= S_TRD;
                    end
                end
                S_DIV: r_state <= S_DWAIT;
                S_DWAIT: if (w_drsp.done) begin
                    unique case (r_axis)
                        2'd0:    r_cx <= w_dq[31:0];
                        2'd1:    r_cy <= w_dq[31:0];
                        default: r_cz <= w_dq[31:0];
                    endcase
                    if (r_axis == 2'd2) begin
                        r_used[r_idx] <= 1'b0;
                        r_any    <= 1'b1;
                        r_ostat  <= vgcd_pkg::ST_CENTROID;
                        // last when no used entry remains above this one
                        r_olast  <= ((r_used >> r_idx) >> 1) == '0;
                        if (((r_used >> r_idx) >> 1) == '0) begin
                            r_held <= '0;
                        end
                        r_ovalid <= 1'b1;
                        r_state  <= S_TOUT;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_DIV;
                    end
                end
                S_TOUT: if (m_axis_tready) begin
                    r_ovalid <= 1'b0;
                    if (r_ostat == vgcd_pkg::ST_CENTROID && !r_olast) begin
                        r_idx <= r_idx + IW'(1);
                        r_state <= S_TRD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [CW-1:0] w_oheld;
    assign w_oheld = (r_ostat == vgcd_pkg::ST_CENTROID || r_ostat == vgcd_pkg::ST_EMPTY)
                     ? '0 : r_held;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {6'd0, w_oheld, r_cz, r_cy, r_cx, r_ostat};
endmodule
